>>> rtl/core/pdgs_pkg.sv
// ----------------------------------------------------------------------------
// Density gradient scaler package
// Shared item types, register indexes and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pdgs_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_START_X       = 3'd0;
	localparam logic [2:0] REG_START_Y       = 3'd1;
	localparam logic [2:0] REG_START_Z       = 3'd2;
	localparam logic [2:0] REG_END_X         = 3'd3;
	localparam logic [2:0] REG_END_Y         = 3'd4;
	localparam logic [2:0] REG_END_Z         = 3'd5;
	localparam logic [2:0] REG_DENSITY_START = 3'd6;
	localparam logic [2:0] REG_DENSITY_END   = 3'd7;

	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;
	localparam int DENS_W    = 24;
	localparam int T_W       = 16;
	localparam int DIFF_W    = 33;
	localparam int PROD_W    = 65;
	localparam int SUM_W     = 66;
	localparam int DIV_STEPS = T_W;

	localparam logic [DENS_W-1:0] DENSITY_RESET = 24'd65536;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] charge_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] charge_out;
		logic               inside_region;
		logic               saturated;
		logic               profile_fault;
	} out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/particle_density_gradient_scale.sv
// ----------------------------------------------------------------------------
// Particle density gradient scaler
// Projects each particle onto the start-to-end segment and scales its charge
// by a linear density ramp when the projection falls strictly inside.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     pdgs_pkg::in_item_t
// out       output     out_valid / out_ready   pdgs_pkg::out_item_t
// cfg       input      cfg_we                  cfg_addr, cfg_wdata
//
// One item enters per cycle unless the output stalls; each passes stages 1-4,
// the 16-stage restoring divider that forms t, stages 21-22 and the output.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_density_gradient_scale (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire pdgs_pkg::in_item_t          in_item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output pdgs_pkg::out_item_t              out_item,
	input  wire logic                        cfg_we,
	input  wire logic [pdgs_pkg::CFG_AW-1:0] cfg_addr,
	input  wire logic [pdgs_pkg::CFG_DW-1:0] cfg_wdata
);
	import pdgs_pkg::*;

	// Configuration registers.
	logic signed [31:0]  start_q [3];
	logic signed [31:0]  end_q [3];
	logic [DENS_W-1:0]   dens_start_q;
	logic [DENS_W-1:0]   dens_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				start_q[i] <= '0;
				end_q[i]   <= '0;
			end
			dens_start_q <= DENSITY_RESET;
			dens_end_q   <= DENSITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_X:       start_q[0]   <= cfg_wdata;
				REG_START_Y:       start_q[1]   <= cfg_wdata;
				REG_START_Z:       start_q[2]   <= cfg_wdata;
				REG_END_X:         end_q[0]     <= cfg_wdata;
				REG_END_Y:         end_q[1]     <= cfg_wdata;
				REG_END_Z:         end_q[2]     <= cfg_wdata;
				REG_DENSITY_START: dens_start_q <= cfg_wdata[DENS_W-1:0];
				REG_DENSITY_END:   dens_end_q   <= cfg_wdata[DENS_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline advances whenever the output register is free or being drained.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Valid bits for each stage.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s21, vld_s22;
	logic [DIV_STEPS:1] vld_sdiv;

	// Stage 1: offsets from the start point, as magnitude and sign.
	logic [DIFF_W-1:0]  amag_s1 [3];
	logic [DIFF_W-1:0]  dmag_s1 [3];
	logic [2:0]         neg_s1;
	logic signed [31:0] charge_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [DIFF_W-1:0] a;
				logic signed [DIFF_W-1:0] d;
				logic signed [31:0]       p;
				p = (i == 0) ? in_item.pos_x : (i == 1) ? in_item.pos_y : in_item.pos_z;
				a = {p[31], p} - {start_q[i][31], start_q[i]};
				d = {end_q[i][31], end_q[i]} - {start_q[i][31], start_q[i]};
				amag_s1[i] <= a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
				dmag_s1[i] <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
				neg_s1[i]  <= a[DIFF_W-1] ^ d[DIFF_W-1];
			end
			charge_s1 <= in_item.charge_in;
		end
	end

	// Stage 2: projection terms and squared segment components.
	logic [PROD_W-1:0]  dot_s2 [3];
	logic [PROD_W-1:0]  sq_s2 [3];
	logic [2:0]         neg_s2;
	logic signed [31:0] charge_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dot_s2[i] <= PROD_W'(amag_s1[i] * dmag_s1[i]);
				sq_s2[i]  <= PROD_W'(dmag_s1[i] * dmag_s1[i]);
			end
			neg_s2    <= neg_s1;
			charge_s2 <= charge_s1;
		end
	end

	// Stage 3: positive and negative partial sums, squared length.
	logic [SUM_W-1:0]   pos_s3, neg_s3, len_s3;
	logic signed [31:0] charge_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			logic [SUM_W-1:0] ps, ns, ls;
			ps = '0;
			ns = '0;
			ls = '0;
			for (int i = 0; i < 3; i++) begin
				if (neg_s2[i]) ns = ns + SUM_W'(dot_s2[i]);
				else           ps = ps + SUM_W'(dot_s2[i]);
				ls = ls + SUM_W'(sq_s2[i]);
			end
			pos_s3    <= ps;
			neg_s3    <= ns;
			len_s3    <= ls;
			charge_s3 <= charge_s2;
		end
	end

	// Stage 4: numerator and the strict inside test.
	logic [SUM_W-1:0]   num_s4, len_s4;
	logic               inside_s4, fault_s4;
	logic signed [31:0] charge_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4    <= pos_s3 - neg_s3;
			inside_s4 <= (pos_s3 > neg_s3) && ((pos_s3 - neg_s3) < len_s3);
			fault_s4  <= (len_s3 == '0);
			len_s4    <= len_s3;
			charge_s4 <= charge_s3;
		end
	end

	// Restoring divider: one quotient bit per stage.
	logic [SUM_W-1:0]   rem_sdiv [DIV_STEPS+1];
	logic [SUM_W-1:0]   len_sdiv [DIV_STEPS+1];
	logic [T_W-1:0]     t_sdiv [DIV_STEPS+1];
	logic               inside_sdiv [DIV_STEPS+1];
	logic               fault_sdiv [DIV_STEPS+1];
	logic signed [31:0] charge_sdiv [DIV_STEPS+1];

	assign rem_sdiv[0]    = num_s4;
	assign len_sdiv[0]    = len_s4;
	assign t_sdiv[0]      = '0;
	assign inside_sdiv[0] = inside_s4;
	assign fault_sdiv[0]  = fault_s4;
	assign charge_sdiv[0] = charge_s4;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [SUM_W:0] shifted;
		logic           ge;
		assign shifted = {rem_sdiv[k], 1'b0};
		assign ge      = shifted >= {1'b0, len_sdiv[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sdiv[k+1]    <= ge ? SUM_W'(shifted - {1'b0, len_sdiv[k]})
				                       : SUM_W'(shifted);
				t_sdiv[k+1]      <= {t_sdiv[k][T_W-2:0], ge};
				len_sdiv[k+1]    <= len_sdiv[k];
				inside_sdiv[k+1] <= inside_sdiv[k];
				fault_sdiv[k+1]  <= fault_sdiv[k];
				charge_sdiv[k+1] <= charge_sdiv[k];
			end
		end
	end

	// Stage 21: linear density factor in Q8.16.
	logic [DENS_W-1:0]  f16_s21;
	logic               apply_s21, inside_s21, fault_s21;
	logic signed [31:0] charge_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			logic [T_W:0]    t, tc;
			logic [DENS_W+T_W+1:0] acc;
			t   = {1'b0, t_sdiv[DIV_STEPS]};
			tc  = 17'd65536 - t;
			acc = (DENS_W+T_W+2)'(dens_start_q * tc) + (DENS_W+T_W+2)'(dens_end_q * t);
			f16_s21    <= acc[DENS_W+T_W-1:T_W];
			apply_s21  <= inside_sdiv[DIV_STEPS] && !fault_sdiv[DIV_STEPS];
			inside_s21 <= inside_sdiv[DIV_STEPS];
			fault_s21  <= fault_sdiv[DIV_STEPS];
			charge_s21 <= charge_sdiv[DIV_STEPS];
		end
	end

	// Stage 22: magnitude of the charge times the factor.
	logic [39:0]        prod_s22;
	logic               apply_s22, inside_s22, fault_s22;
	logic signed [31:0] charge_s22;

	always_ff @(posedge clk) begin
		if (en) begin
			logic [31:0] cmag;
			logic [55:0] p;
			cmag = charge_s21[31] ? 32'(-charge_s21) : 32'(charge_s21);
			p    = 56'(cmag * f16_s21);
			prod_s22   <= p[55:16];
			apply_s22  <= apply_s21;
			inside_s22 <= inside_s21;
			fault_s22  <= fault_s21;
			charge_s22 <= charge_s21;
		end
	end

	// Output register: sign restore and saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			out_item.inside_region <= inside_s22;
			out_item.profile_fault <= fault_s22;
			if (!apply_s22) begin
				out_item.charge_out <= charge_s22;
				out_item.saturated  <= 1'b0;
			end else if (charge_s22[31]) begin
				if (prod_s22 > 40'h0080000000) begin
					out_item.charge_out <= 32'sh80000000;
					out_item.saturated  <= 1'b1;
				end else begin
					out_item.charge_out <= 32'(-prod_s22);
					out_item.saturated  <= 1'b0;
				end
			end else if (prod_s22 > 40'h007FFFFFFF) begin
				out_item.charge_out <= 32'sh7FFFFFFF;
				out_item.saturated  <= 1'b1;
			end else begin
				out_item.charge_out <= prod_s22[31:0];
				out_item.saturated  <= 1'b0;
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_sdiv  <= '0;
			vld_s21   <= 1'b0;
			vld_s22   <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_sdiv  <= {vld_sdiv[DIV_STEPS-1:1], vld_s4};
			vld_s21   <= vld_sdiv[DIV_STEPS];
			vld_s22   <= vld_s21;
			out_valid <= vld_s22;
		end
	end

endmodule

`default_nettype wire
